@@ rtl/scrolling_text_console_buffer_core_defines.svh @@
// assertion macros for the scrolling text console buffer checker
`ifndef SCROLLING_TEXT_CONSOLE_BUFFER_CORE_DEFINES_SVH
`define SCROLLING_TEXT_CONSOLE_BUFFER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define STCB_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stcb check failed");

// next-cycle implication, sampled on clk, off during rst
`define STCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stcb check failed");

`endif

@@ rtl/stcb_pkg.sv @@
// shared constants and types of the scrolling text console buffer
`timescale 1ns / 1ps
package stcb_pkg;

  localparam int GRID_ROWS = 32;
  localparam int GRID_COLS = 32;
  localparam int DEPTH     = GRID_ROWS * GRID_COLS;

  localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int CUR_W  = $clog2(GRID_COLS + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CHAR_W = 7;
  localparam int RNG_W  = 9;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/scrolling_text_console_buffer_core.sv @@
// top level of the scrolling text console buffer
//
//   channel  signals                             word
//   in       in_valid, in_stall                  op, char_byte, row, col
//   out      out_valid, out_stall                cell_char
//
// a plain put word is written as it is taken; a newline scrolls, clearing the recycled
// row one cell a cycle through the grid memory port
// a printable word on a full row scrolls first, then writes in ST_PUT
// a read word goes through the registered memory read into the result register, and
// waits while the previous result is still held by out_stall
// after rst the grid is swept to spaces with in_stall high
// puts are taken while a result waits on out_stall; a read waits for the slot
`timescale 1ns / 1ps
module scrolling_text_console_buffer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [7:0]                  char_byte,
  input  logic [4:0]                  row,
  input  logic [4:0]                  col,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stcb_pkg::CHAR_W-1:0] cell_char
);
  import stcb_pkg::*;

  mem_req_t          mem_req;
  logic [CHAR_W-1:0] mem_rdata;

  stcb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .char_byte (char_byte),
    .row       (row),
    .col       (col),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_char (cell_char),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  stcb_grid_mem u_grid_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

@@ rtl/stcb_grid_mem.sv @@
// character grid memory, one write and one registered read port
`timescale 1ns / 1ps
module stcb_grid_mem (
  input  logic                              clk,
  input  stcb_pkg::mem_req_t                req,
  output logic [stcb_pkg::CHAR_W-1:0]       rdata
);
  import stcb_pkg::*;

  logic [CHAR_W-1:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      cells[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= cells[req.raddr];
    end
  end

endmodule

@@ rtl/stcb_ctrl.sv @@
// byte decoding, scroll and clear sequencing, read path and result register
`timescale 1ns / 1ps
module stcb_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        op,
  input  logic [7:0]                  char_byte,
  input  logic [4:0]                  row,
  input  logic [4:0]                  col,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [stcb_pkg::CHAR_W-1:0] cell_char,
  output stcb_pkg::mem_req_t          mem_req,
  input  logic [stcb_pkg::CHAR_W-1:0] mem_rdata
);
  import stcb_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_SCROLL = 3'd2;
  localparam logic [2:0] ST_PUT    = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;

  logic [2:0]        state;
  logic [ADDR_W-1:0] sweep;
  logic [COL_W-1:0]  scol;
  logic [ROW_W-1:0]  top_row;
  logic [CUR_W-1:0]  cursor;
  logic              esc;
  logic              pend;
  logic [CHAR_W-1:0] pend_char;
  logic              oor;

  logic              accept;
  logic [ROW_W-1:0]  bottom_row;
  logic [7:0]        put_char;
  logic              printable;
  logic              is_letter;
  logic              row_full;
  logic              put_write;
  logic              in_range;
  logic [ROW_W:0]    psum;
  logic [ROW_W-1:0]  prow;
  logic [ADDR_W-1:0] read_addr;

  function automatic logic [ADDR_W-1:0] row_base(input logic [ROW_W-1:0] r);
    return ADDR_W'(r) * ADDR_W'(GRID_COLS);
  endfunction

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    bottom_row = (top_row == '0) ? ROW_W'(GRID_ROWS - 1) : top_row - 1'b1;
    put_char   = (char_byte == CH_TAB) ? CH_SPACE : char_byte;
    printable  = (put_char >= CH_PRINT_LO) && (put_char <= CH_PRINT_HI);
    is_letter  = char_byte inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z]};
    row_full   = (cursor == CUR_W'(GRID_COLS));
    put_write  = !esc && (char_byte != CH_ESC) && (char_byte != CH_CR) &&
                 (char_byte != CH_LF) && printable && !row_full;
    in_range   = (RNG_W'(row) < RNG_W'(GRID_ROWS)) && (RNG_W'(col) < RNG_W'(GRID_COLS));
    psum       = {1'b0, top_row} + (ROW_W + 1)'(row);
    if (psum >= (ROW_W + 1)'(GRID_ROWS)) begin
      psum = psum - (ROW_W + 1)'(GRID_ROWS);
    end
    prow      = psum[ROW_W-1:0];
    read_addr = row_base(prow) + ADDR_W'(col);
  end

  always_comb begin
    mem_req = '0;
    case (state)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = sweep;
        mem_req.wdata = CH_SPACE[CHAR_W-1:0];
      end
      ST_SCROLL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = row_base(top_row) + ADDR_W'(scol);
        mem_req.wdata = CH_SPACE[CHAR_W-1:0];
      end
      ST_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = row_base(bottom_row) + ADDR_W'(COL_W'(cursor));
        mem_req.wdata = pend_char;
      end
      ST_IDLE: begin
        if (accept && op == OP_READ) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = read_addr;
        end else if (accept && put_write) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = row_base(bottom_row) + ADDR_W'(COL_W'(cursor));
          mem_req.wdata = put_char[CHAR_W-1:0];
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      sweep     <= '0;
      scol      <= '0;
      top_row   <= '0;
      cursor    <= '0;
      esc       <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != ST_READ) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (op == OP_READ) begin
              oor   <= !in_range;
              state <= ST_READ;
            end else if (esc) begin
              if (is_letter) begin
                esc <= 1'b0;
              end
            end else if (char_byte == CH_ESC) begin
              esc <= 1'b1;
            end else if (char_byte == CH_CR) begin
              esc <= 1'b0;
            end else if (char_byte == CH_LF) begin
              scol  <= '0;
              pend  <= 1'b0;
              state <= ST_SCROLL;
            end else if (printable) begin
              if (row_full) begin
                scol      <= '0;
                pend      <= 1'b1;
                pend_char <= put_char[CHAR_W-1:0];
                state     <= ST_SCROLL;
              end else begin
                cursor <= cursor + 1'b1;
              end
            end
          end
        end
        ST_SCROLL: begin
          scol <= scol + 1'b1;
          if (scol == COL_W'(GRID_COLS - 1)) begin
            top_row <= (top_row == ROW_W'(GRID_ROWS - 1)) ? '0 : top_row + 1'b1;
            cursor  <= '0;
            state   <= pend ? ST_PUT : ST_IDLE;
          end
        end
        ST_PUT: begin
          cursor <= cursor + 1'b1;
          state  <= ST_IDLE;
        end
        ST_READ: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            cell_char <= oor ? CH_SPACE[CHAR_W-1:0] : mem_rdata;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/stcb_checker.sv @@
// port-level checker for the scrolling text console buffer, with its bind
`timescale 1ns / 1ps
`include "scrolling_text_console_buffer_core_defines.svh"
module stcb_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [stcb_pkg::CHAR_W-1:0] cell_char
);
  import stcb_pkg::*;

  localparam logic [CHAR_W-1:0] GLYPH_LO = CH_PRINT_LO[CHAR_W-1:0];
  localparam logic [CHAR_W-1:0] GLYPH_HI = CH_PRINT_HI[CHAR_W-1:0];

  // a held result stays
  `STCB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // a held result keeps its value
  `STCB_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(cell_char))
  // no result appears the cycle after any word taken with the slot empty
  `STCB_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall && !out_valid, !out_valid)
  // the grid only ever holds printable characters
  `STCB_ASSERT_SAME(a_printable, out_valid, (cell_char >= GLYPH_LO) && (cell_char <= GLYPH_HI))

endmodule

bind scrolling_text_console_buffer_core stcb_checker u_stcb_checker (.*);
